@@ rtl/core/tpio_pkg.sv @@
// ----------------------------------------------------------------------------
// tpio_pkg
// Shared types and codes for the trapped port I/O emulator: opcode and
// prefix bytes, emulated port numbers and the decode result bundle.
// ----------------------------------------------------------------------------
package tpio_pkg;

  localparam int DEF_PALETTE_BYTES = 768;

  // prefixes
  localparam logic [7:0] OP_OPSIZE   = 8'h66;
  localparam logic [7:0] OP_ADDRSIZE = 8'h67;

  // skipped privileged instructions
  localparam logic [7:0] OP_CLI      = 8'hFA;
  localparam logic [7:0] OP_STI      = 8'hFB;
  localparam logic [7:0] OP_POP_ES   = 8'h07;
  localparam logic [7:0] OP_POP_SS   = 8'h17;
  localparam logic [7:0] OP_POP_DS   = 8'h1F;
  localparam logic [7:0] OP_MOV_SREG = 8'h8E;
  localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
  localparam logic [7:0] OP_POP_FS   = 8'hA1;
  localparam logic [7:0] OP_POP_GS   = 8'hA9;

  // port I/O
  localparam logic [7:0] OP_IN_IMM8   = 8'hE4;
  localparam logic [7:0] OP_IN_IMM16  = 8'hE5;
  localparam logic [7:0] OP_OUT_IMM8  = 8'hE6;
  localparam logic [7:0] OP_OUT_IMM16 = 8'hE7;
  localparam logic [7:0] OP_IN_DX8    = 8'hEC;
  localparam logic [7:0] OP_IN_DX16   = 8'hED;
  localparam logic [7:0] OP_OUT_DX8   = 8'hEE;
  localparam logic [7:0] OP_OUT_DX16  = 8'hEF;

  // emulated ports
  localparam logic [15:0] PORT_DAC_INDEX = 16'h03C8;
  localparam logic [15:0] PORT_DAC_DATA  = 16'h03C9;
  localparam logic [15:0] PORT_PIT_CH0   = 16'h0040;

  localparam logic [7:0] TOGGLE_MASK = 8'hFF;

  typedef struct packed {
    logic        handled;
    logic [3:0]  skip_length;
    logic        is_in;
    logic        is_out;
    logic        wide;
    logic [15:0] port;
  } tpio_dec_t;

endpackage

@@ rtl/core/trapped_port_io_emulator.sv @@
// ----------------------------------------------------------------------------
// trapped_port_io_emulator
// Emulates trapped port I/O and skips privileged instructions; holds the
// DAC palette in an on-chip memory.
// ----------------------------------------------------------------------------
// One transfer is taken per clock cycle, back to back, while in_stall is
// low, and its result appears in the output register in the cycle after it
// is taken; the palette memory has a single write port and a single read
// port, and there is one output stage. After reset the block clears the
// palette memory one byte a cycle and holds in_stall high until the sweep is
// done. A palette read (cmd 1) sees every palette write accepted before it.
// ----------------------------------------------------------------------------
module trapped_port_io_emulator #(
  parameter int PALETTE_BYTES = tpio_pkg::DEF_PALETTE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  op_byte0,
  input  logic [7:0]  op_byte1,
  input  logic [7:0]  op_byte2,
  input  logic [15:0] dx_port,
  input  logic [7:0]  acc_byte,
  input  logic [9:0]  palette_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        handled,
  output logic [3:0]  skip_length,
  output logic        read_valid,
  output logic        read_wide,
  output logic [7:0]  read_value,
  output logic        divisor_valid,
  output logic [15:0] divisor,
  output logic [7:0]  palette_data
);
  import tpio_pkg::*;

  localparam int IW = $clog2(PALETTE_BYTES);
  localparam logic [IW-1:0] LAST_IDX = IW'(PALETTE_BYTES - 1);

  typedef logic [IW-1:0] idx_tab_t [256];

  // AL*3 mod PALETTE_BYTES, built at elaboration
  function automatic idx_tab_t build_idx_tab();
    idx_tab_t tab;
    int       v;
    v = 0;
    for (int k = 0; k < 256; k++) begin
      tab[k] = IW'(v);
      v = v + 3;
      if (v >= PALETTE_BYTES) v = v - PALETTE_BYTES;
    end
    return tab;
  endfunction

  localparam idx_tab_t IDX_TAB = build_idx_tab();

  tpio_dec_t dec;

  logic          accept;
  logic          clearing;
  logic [IW-1:0] clr_addr;
  logic [IW-1:0] palette_index;
  logic [7:0]    divisor_low;
  logic          low_pending;
  logic          toggle;

  logic [7:0]    palette [PALETTE_BYTES];
  logic [7:0]    rdata;
  logic          rd_sel;

  logic          addr_ok;
  logic          do_in;
  logic          do_out;
  logic          dac_index_wr;
  logic          dac_data_wr;
  logic          pit_wr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  tpio_decode u_decode (
    .op_byte0 (op_byte0),
    .op_byte1 (op_byte1),
    .op_byte2 (op_byte2),
    .dx_port  (dx_port),
    .dec      (dec)
  );

  assign in_stall = clearing || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    addr_ok      = palette_addr < 10'(PALETTE_BYTES);
    do_in        = accept && !cmd && dec.is_in;
    do_out       = accept && !cmd && dec.is_out;
    dac_index_wr = do_out && (dec.port == PORT_DAC_INDEX);
    dac_data_wr  = do_out && (dec.port == PORT_DAC_DATA);
    pit_wr       = do_out && (dec.port == PORT_PIT_CH0);
    mem_we       = clearing || dac_data_wr;
    mem_waddr    = clearing ? clr_addr : palette_index;
    mem_wdata    = clearing ? 8'h00 : acc_byte;
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (mem_we) palette[mem_waddr] <= mem_wdata;
    if (accept && cmd && addr_ok) rdata <= palette[palette_addr[IW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      palette_index <= '0;
      low_pending   <= 1'b0;
      toggle        <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_IDX) clearing <= 1'b0;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (dac_index_wr) palette_index <= IDX_TAB[acc_byte];
      if (dac_data_wr) palette_index <= (palette_index == LAST_IDX) ? '0 : palette_index + 1'b1;
      if (pit_wr) low_pending <= !low_pending;
      if (do_in) toggle <= !toggle;
    end
  end

  always_ff @(posedge clk) begin
    if (pit_wr && !low_pending) divisor_low <= acc_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (accept) begin
      handled       <= !cmd && dec.handled;
      skip_length   <= cmd ? 4'd0 : dec.skip_length;
      read_valid    <= do_in;
      read_wide     <= do_in && dec.wide;
      read_value    <= do_in ? (toggle ? 8'h00 : TOGGLE_MASK) : 8'h00;
      divisor_valid <= pit_wr && low_pending;
      divisor       <= (pit_wr && low_pending) ? {acc_byte, divisor_low} : 16'h0000;
      rd_sel        <= cmd && addr_ok;
    end
  end

  assign palette_data = rd_sel ? rdata : 8'h00;

  // assertions
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("transfer accepted during palette clear");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    palette_index <= LAST_IDX)
    else $error("palette index out of range");

  a_handled_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && handled |-> skip_length != 4'd0 && skip_length <= 4'd8)
    else $error("handled result with bad skip length");

  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    do_in |=> toggle != $past(toggle))
    else $error("in transfer did not flip read toggle");

  a_divisor_pairs: assert property (@(posedge clk) disable iff (rst)
    pit_wr && !low_pending |=> low_pending)
    else $error("low divisor byte not held");

endmodule

@@ rtl/core/tpio_decode.sv @@
// ----------------------------------------------------------------------------
// tpio_decode
// Instruction length and class decode for one trapped instruction: skipped
// privileged forms with ModRM/SIB/displacement length, and in/out forms.
// ----------------------------------------------------------------------------
module tpio_decode (
  input  logic [7:0]            op_byte0,
  input  logic [7:0]            op_byte1,
  input  logic [7:0]            op_byte2,
  input  logic [15:0]           dx_port,
  output tpio_pkg::tpio_dec_t   dec
);
  import tpio_pkg::*;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_DISP32  = 3'd5;

  logic       pre;
  logic [7:0] q;
  logic [7:0] nxt;
  logic [1:0] mod_f;
  logic [2:0] rm_f;
  logic [3:0] skip;
  logic       wide;
  logic [7:0] op;
  logic [7:0] pnxt;
  logic       is_in;
  logic       is_out;
  logic       imm;
  logic [3:0] ilen;

  always_comb begin
    pre   = (op_byte0 == OP_OPSIZE) || (op_byte0 == OP_ADDRSIZE);
    q     = pre ? op_byte1 : op_byte0;
    nxt   = pre ? op_byte2 : op_byte1;
    mod_f = nxt[7:6];
    rm_f  = nxt[2:0];
    skip  = 4'd0;
    unique case (q) inside
      OP_CLI, OP_STI, OP_POP_ES, OP_POP_SS, OP_POP_DS: begin
        skip = {3'b000, pre} + 4'd1;
      end
      OP_MOV_SREG: begin
        skip = {3'b000, pre} + 4'd2;
        if (mod_f != MOD_REG) begin
          if (rm_f == RM_SIB) skip = skip + 4'd1;
          if (mod_f == MOD_DISP8) begin
            skip = skip + 4'd1;
          end else if (mod_f == MOD_DISP32) begin
            skip = skip + 4'd4;
          end else if (mod_f == MOD_NODISP && rm_f == RM_DISP32) begin
            skip = skip + 4'd4;
          end
        end
      end
      OP_TWO_BYTE: begin
        if (nxt == OP_POP_FS || nxt == OP_POP_GS) skip = {3'b000, pre} + 4'd2;
      end
      default: begin
        skip = 4'd0;
      end
    endcase

    // port i/o takes the operand-size prefix only
    wide   = (op_byte0 == OP_OPSIZE);
    op     = wide ? op_byte1 : op_byte0;
    pnxt   = wide ? op_byte2 : op_byte1;
    is_in  = 1'b0;
    is_out = 1'b0;
    imm    = 1'b0;
    unique case (op) inside
      OP_IN_IMM8, OP_IN_IMM16: begin
        is_in = 1'b1;
        imm   = 1'b1;
      end
      OP_OUT_IMM8, OP_OUT_IMM16: begin
        is_out = 1'b1;
        imm    = 1'b1;
      end
      OP_IN_DX8, OP_IN_DX16: begin
        is_in = 1'b1;
      end
      OP_OUT_DX8, OP_OUT_DX16: begin
        is_out = 1'b1;
      end
      default: begin
        is_in = 1'b0;
      end
    endcase
    ilen = {3'b000, wide} + 4'd1 + {3'b000, imm};

    dec.is_in       = (skip == 4'd0) && is_in;
    dec.is_out      = (skip == 4'd0) && is_out;
    dec.wide        = wide;
    dec.port        = imm ? {8'h00, pnxt} : dx_port;
    dec.handled     = (skip != 4'd0) || is_in || is_out;
    if (skip != 4'd0) begin
      dec.skip_length = skip;
    end else if (is_in || is_out) begin
      dec.skip_length = ilen;
    end else begin
      dec.skip_length = 4'd0;
    end
  end

endmodule
